[hw/rtl/tclb_pkg.sv]
// ----------------------------------------------------------------------------
// Tone curve inverse table builder package
// Shared sizes, request codes and the end smoothing result type.
// ----------------------------------------------------------------------------
package tclb_pkg;

   localparam int MAX_IN_BITS  = 14;
   localparam int MAX_OUT_BITS = 16;
   localparam int FWD_DEPTH    = 1 << MAX_IN_BITS;
   localparam int INV_DEPTH    = 1 << MAX_OUT_BITS;
   localparam int MIN_BITS     = 8;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_BUILD = 2'd1,
      REQ_READ  = 2'd2
   } req_code_type;

   localparam logic CSR_OUT_DEPTH = 1'b0;
   localparam logic CSR_IN_DEPTH  = 1'b1;

   // Result of the end smoothing check for one end of the inverse table.
   typedef struct packed {
      logic                   wr;
      logic [MAX_IN_BITS-1:0] value;
   } smooth_type;

endpackage

[hw/rtl/tclb_smooth.sv]
// ----------------------------------------------------------------------------
// Tone curve inverse table end smoothing
// Decides whether an end entry is replaced by a linear extrapolation.
// ----------------------------------------------------------------------------
module tclb_smooth (
   input  logic [tclb_pkg::MAX_IN_BITS-1:0] i1,
   input  logic [tclb_pkg::MAX_IN_BITS-1:0] i2,
   input  logic [tclb_pkg::MAX_IN_BITS-1:0] i3,
   input  logic [tclb_pkg::MAX_IN_BITS-1:0] inmax,
   output tclb_pkg::smooth_type              res
);

   logic [tclb_pkg::MAX_IN_BITS-1:0]   d1;
   logic [tclb_pkg::MAX_IN_BITS-1:0]   d2;
   logic signed [tclb_pkg::MAX_IN_BITS+1:0] ext;

   always_comb begin
      d1  = (i1 > i2) ? i1 - i2 : i2 - i1;
      d2  = (i3 > i2) ? i3 - i2 : i2 - i3;
      ext = $signed({1'b0, i2, 1'b0}) - $signed({2'b00, i3});
      res.wr = {1'b0, d1} > {d2, 1'b0};
      // The extrapolated value is clamped into the internal index range.
      if (ext < 0) begin
         res.value = '0;
      end else if (ext > $signed({2'b00, inmax})) begin
         res.value = inmax;
      end else begin
         res.value = ext[tclb_pkg::MAX_IN_BITS-1:0];
      end
   end

endmodule

[hw/rtl/tone_curve_inverse_lut_builder.sv]
// ----------------------------------------------------------------------------
// Tone curve inverse table builder
// Holds a forward tone curve and builds and serves its inverse table.
// ----------------------------------------------------------------------------
// A forward write gives no result and leaves the block idle, so writes can
// follow back to back. An inverse read is answered from the registered read
// port of the inverse table memory: the block passes through S_READ, where it
// registers the result once the result channel is free, and takes the next
// request when the result is presented, so a read is finished before the next
// is taken. A result that waits for rsp_tready holds the next result, and a
// block in S_READ or S_RESP, until it is taken. A build clears the inverse
// table, reads, compares and steps over each forward entry, fills for each
// jump in the saturated forward curve every external value that the jump
// crosses, then finishes and smooths both ends, all bound by the single
// write port of the inverse table. No request is taken while a build runs.
// The result of a build has build_done set and read data zero.
module tone_curve_inverse_lut_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // table_addr[15:0], entry_value[31:16]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_data[13:0], zero fill[15:14]
   output logic        rsp_tuser,   // build_done
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam int IW = tclb_pkg::MAX_IN_BITS;
   localparam int OW = tclb_pkg::MAX_OUT_BITS;

   typedef enum logic [14:0] {
      S_IDLE  = 15'b000000000000001,
      S_READ  = 15'b000000000000010,
      S_CLEAR = 15'b000000000000100,
      S_TOP   = 15'b000000000001000,
      S_CMP   = 15'b000000000010000,
      S_RUN1  = 15'b000000000100000,
      S_RUN2  = 15'b000000001000000,
      S_STEP  = 15'b000000010000000,
      S_WAIT  = 15'b000000100000000,
      S_FINAL = 15'b000001000000000,
      S_SM0   = 15'b000010000000000,
      S_SM1   = 15'b000100000000000,
      S_SM2   = 15'b001000000000000,
      S_SM3   = 15'b010000000000000,
      S_RESP  = 15'b100000000000000
   } state_type;

   // Memories: forward curve and inverse table, both with registered reads.
   logic [OW-1:0] fwd_mem_ff [tclb_pkg::FWD_DEPTH];
   logic [IW-1:0] inv_mem_ff [tclb_pkg::INV_DEPTH];
   logic [OW-1:0] fwd_q_ff;
   logic [IW-1:0] inv_q_ff;

   state_type     state_ff, state_in;
   logic [4:0]    out_bits_ff, out_bits_in;
   logic [3:0]    in_bits_ff, in_bits_in;
   logic [OW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] j_ff, j_in;
   logic [IW-1:0] lastj_ff, lastj_in;
   logic [IW-1:0] anchor_ff, anchor_in;
   logic [OW-1:0] last_ff, last_in;
   logic [OW-1:0] cur_ff, cur_in;
   logic [OW-1:0] mid_ff, mid_in;
   logic          filled_ff, filled_in;
   logic          end_ff, end_in;
   logic [IW-1:0] i1_ff, i1_in;
   logic [IW-1:0] i2_ff, i2_in;
   logic [OW-1:0] addr_ff, addr_in;
   logic          oob_ff, oob_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_done_ff, rsp_done_in;

   logic [OW-1:0] outmax;
   logic [IW-1:0] inmax;
   logic [OW-1:0] thresh;
   logic [OW-1:0] fwd_sat;
   logic [OW-1:0] req_addr;
   logic [OW-1:0] req_value;
   logic          req_xfer;
   logic          out_free;
   logic          fwd_we;
   logic          inv_we;
   logic [OW-1:0] inv_wa;
   logic [IW-1:0] inv_wd;
   logic [OW-1:0] inv_ra;
   logic [OW-1:0] e0, e1, e2;
   logic [OW:0]   pair_sum;
   tclb_pkg::smooth_type smooth;

   assign outmax    = OW'((17'd1 << out_bits_ff) - 17'd1);
   assign inmax     = IW'((15'd1 << in_bits_ff) - 15'd1);
   // Three quarters of the external range; a lower top value means a flat tail.
   assign thresh    = OW'(17'd3 << (out_bits_ff - 5'd2));
   assign fwd_sat   = (fwd_q_ff > outmax) ? outmax : fwd_q_ff;
   assign req_addr  = req_tdata[15:0];
   assign req_value = req_tdata[31:16];
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pair_sum  = (OW+1)'(fwd_sat) + (OW+1)'(last_ff);

   assign e0 = end_ff ? outmax          : OW'(0);
   assign e1 = end_ff ? outmax - OW'(1) : OW'(1);
   assign e2 = end_ff ? outmax - OW'(2) : OW'(2);

   tclb_smooth u_smooth (
      .i1    (i1_ff),
      .i2    (i2_ff),
      .i3    (inv_q_ff),
      .inmax (inmax),
      .res   (smooth)
   );

   // Configuration writes clamp each depth into its supported range.
   always_comb begin
      out_bits_in = out_bits_ff;
      in_bits_in  = in_bits_ff;
      if (csr_we) begin
         case (csr_index)
            tclb_pkg::CSR_OUT_DEPTH: begin
               if (csr_wdata < 5'(tclb_pkg::MIN_BITS)) begin
                  out_bits_in = 5'(tclb_pkg::MIN_BITS);
               end else if (csr_wdata > 5'(OW)) begin
                  out_bits_in = 5'(OW);
               end else begin
                  out_bits_in = csr_wdata;
               end
            end
            tclb_pkg::CSR_IN_DEPTH: begin
               if (csr_wdata[3:0] < 4'(tclb_pkg::MIN_BITS)) begin
                  in_bits_in = 4'(tclb_pkg::MIN_BITS);
               end else if (csr_wdata[3:0] > 4'(IW)) begin
                  in_bits_in = 4'(IW);
               end else begin
                  in_bits_in = csr_wdata[3:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Inverse table read address follows the state that needs the data next.
   always_comb begin
      case (state_ff)
         S_IDLE:  inv_ra = req_addr;
         S_SM0:   inv_ra = e0;
         S_SM1:   inv_ra = e1;
         S_SM2:   inv_ra = e2;
         default: inv_ra = addr_ff;
      endcase
   end

   // Main sequencer. The build walk keeps "last" as the external value that
   // was reached so far and fills the gap to the current value one entry a
   // cycle: first the half next to the previous index, then the rest.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      j_in         = j_ff;
      lastj_in     = lastj_ff;
      anchor_in    = anchor_ff;
      last_in      = last_ff;
      cur_in       = cur_ff;
      mid_in       = mid_ff;
      filled_in    = filled_ff;
      end_in       = end_ff;
      i1_in        = i1_ff;
      i2_in        = i2_ff;
      addr_in      = addr_ff;
      oob_in       = oob_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_done_in  = rsp_done_ff;
      fwd_we       = 1'b0;
      inv_we       = 1'b0;
      inv_wa       = last_ff;
      inv_wd       = lastj_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_tuser)
                  tclb_pkg::REQ_WRITE: begin
                     fwd_we = (req_addr <= {2'b00, inmax});
                  end
                  tclb_pkg::REQ_BUILD: begin
                     cnt_in   = '0;
                     j_in     = inmax;
                     state_in = S_CLEAR;
                  end
                  tclb_pkg::REQ_READ: begin
                     addr_in  = req_addr;
                     oob_in   = req_addr > outmax;
                     state_in = S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = oob_ff ? '0 : inv_q_ff;
               rsp_done_in  = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_CLEAR: begin
            inv_we = 1'b1;
            inv_wa = cnt_ff;
            inv_wd = '0;
            if (cnt_ff == outmax) begin
               state_in = S_TOP;
            end else begin
               cnt_in = cnt_ff + OW'(1);
            end
         end
         S_TOP: begin
            last_in   = (fwd_sat < thresh) ? outmax : fwd_sat;
            lastj_in  = j_ff;
            anchor_in = j_ff;
            filled_in = 1'b0;
            state_in  = S_CMP;
         end
         S_CMP: begin
            cur_in = fwd_sat;
            if (fwd_sat == last_ff) begin
               // Flat run: its midpoint index owns this value.
               inv_we    = 1'b1;
               inv_wa    = last_ff;
               inv_wd    = IW'(((IW+1)'(anchor_ff) + (IW+1)'(j_ff)) >> 1);
               filled_in = 1'b1;
               state_in  = S_STEP;
            end else begin
               if (last_ff > fwd_sat) begin
                  mid_in = OW'(((pair_sum + (OW+1)'(1)) >> 1) - (OW+1)'(1));
               end else begin
                  mid_in = OW'((pair_sum >> 1) + (OW+1)'(1));
               end
               state_in = S_RUN1;
            end
         end
         S_RUN1: begin
            if (last_ff != mid_ff) begin
               inv_we    = !filled_ff;
               inv_wa    = last_ff;
               inv_wd    = lastj_ff;
               last_in   = (last_ff > mid_ff) ? last_ff - OW'(1) : last_ff + OW'(1);
               filled_in = 1'b0;
            end else begin
               state_in = S_RUN2;
            end
         end
         S_RUN2: begin
            if (last_ff != cur_ff) begin
               inv_we    = !filled_ff;
               inv_wa    = last_ff;
               inv_wd    = j_ff;
               last_in   = (last_ff > cur_ff) ? last_ff - OW'(1) : last_ff + OW'(1);
               filled_in = 1'b0;
            end else begin
               anchor_in = j_ff;
               state_in  = S_STEP;
            end
         end
         S_STEP: begin
            lastj_in = j_ff;
            last_in  = cur_ff;
            if (j_ff == '0) begin
               state_in = S_FINAL;
            end else begin
               j_in     = j_ff - IW'(1);
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_CMP;
         end
         S_FINAL: begin
            // A walk that ends on a jump leaves its last value unfilled.
            inv_we   = !filled_ff;
            inv_wa   = last_ff;
            inv_wd   = lastj_ff;
            end_in   = 1'b0;
            state_in = S_SM0;
         end
         S_SM0: begin
            state_in = S_SM1;
         end
         S_SM1: begin
            i1_in    = inv_q_ff;
            state_in = S_SM2;
         end
         S_SM2: begin
            i2_in    = inv_q_ff;
            state_in = S_SM3;
         end
         S_SM3: begin
            inv_we = smooth.wr;
            inv_wa = e0;
            inv_wd = smooth.value;
            if (!end_ff) begin
               end_in   = 1'b1;
               state_in = S_SM0;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_done_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (fwd_we) begin
         fwd_mem_ff[req_addr[IW-1:0]] <= req_value;
      end
      fwd_q_ff <= fwd_mem_ff[j_ff];
   end

   always_ff @(posedge clock) begin
      if (inv_we) begin
         inv_mem_ff[inv_wa] <= inv_wd;
      end
      inv_q_ff <= inv_mem_ff[inv_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_bits_ff  <= 5'(tclb_pkg::MIN_BITS);
         in_bits_ff   <= 4'(tclb_pkg::MIN_BITS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_bits_ff  <= out_bits_in;
         in_bits_ff   <= in_bits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      j_ff        <= j_in;
      lastj_ff    <= lastj_in;
      anchor_ff   <= anchor_in;
      last_ff     <= last_in;
      cur_ff      <= cur_in;
      mid_ff      <= mid_in;
      filled_ff   <= filled_in;
      end_ff      <= end_in;
      i1_ff       <= i1_in;
      i2_ff       <= i2_in;
      addr_ff     <= addr_in;
      oob_ff      <= oob_in;
      rsp_data_ff <= rsp_data_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};
   assign rsp_tuser  = rsp_done_ff;

`ifndef NO_ASSERTIONS
   a_inv_wr_range: assert property (@(posedge clock) disable iff (reset)
      inv_we |-> inv_wa <= outmax)
      else $error("inverse table write beyond the external range");

   a_build_starts_clear: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tuser == tclb_pkg::REQ_BUILD |=> state_ff == S_CLEAR)
      else $error("build transfer did not start the clearing sweep");

   a_done_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_data_ff == '0)
      else $error("build result carries nonzero data");

   a_no_fwd_write_busy: assert property (@(posedge clock) disable iff (reset)
      fwd_we |-> state_ff == S_IDLE)
      else $error("forward write outside idle");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Tone curve inverse table builder testbench
// Loads forward tone curves, requests inverse builds and reads back the
// inverse table, checking every result against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [4:0]  csr_wdata = '0;

   // Request type 3 is not a defined code; it is named here so that it is
   // never written as a bare number.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   tone_curve_inverse_lut_builder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The run is bounded by a fixed time well beyond the slowest correct run,
   // which is dominated by builds over noisy curves where every jump is long.
   initial begin
      #200ms;
      $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Behavioral copy of the block: both tables and the saturated depths.
   // ------------------------------------------------------------------------
   typedef struct {
      logic [13:0] read_data;
      logic        build_done;
   } inv_result_type;

   logic [15:0]     curve_mem [tclb_pkg::FWD_DEPTH];
   logic [13:0]     inverse_mem [tclb_pkg::INV_DEPTH];
   int              out_bits = tclb_pkg::MIN_BITS;
   int              in_bits = tclb_pkg::MIN_BITS;
   int              built_top = -1;   // highest inverse entry written by a build
   inv_result_type  pending_results[$];
   int              mismatch_count = 0;

   function automatic int curve_at(int idx, int outmax);
      int v;
      v = curve_mem[idx & (tclb_pkg::FWD_DEPTH - 1)];
      return (v > outmax) ? outmax : v;
   endfunction

   function automatic void inverse_put(int idx, int v);
      inverse_mem[idx & (tclb_pkg::INV_DEPTH - 1)] = v[13:0];
   endfunction

   function automatic void smooth_end(int e0, int e1, int e2, int inmax);
      int i1, i2, i3, d1, d2, v;
      i1 = inverse_mem[e0];
      i2 = inverse_mem[e1];
      i3 = inverse_mem[e2];
      d1 = (i1 > i2) ? i1 - i2 : i2 - i1;
      d2 = (i3 > i2) ? i3 - i2 : i2 - i3;
      if (d1 > 2 * d2) begin
         v = 2 * i2 - i3;
         if (v < 0) v = 0;
         if (v > inmax) v = inmax;
         inverse_put(e0, v);
      end
   endfunction

   // Walk the curve from its top index down, filling flat runs with their
   // midpoint index and splitting each jump between its two neighbors.
   function automatic void build_inverse_table();
      int outmax, inmax, j, prev_j, anchor, prev_v, cur, mid;
      bit flat_filled;
      outmax = (1 << out_bits) - 1;
      inmax = (1 << in_bits) - 1;
      prev_j = inmax;
      anchor = inmax;
      flat_filled = 1'b0;
      for (int k = 0; k <= outmax; k++) inverse_mem[k] = '0;
      prev_v = curve_at(inmax, outmax);
      // A low top value hints at a flat tail above it.
      if (prev_v < (((outmax + 1) * 3) >> 2)) prev_v = outmax;
      for (j = inmax; j >= 0; j--) begin
         cur = curve_at(j, outmax);
         if (cur == prev_v) begin
            inverse_put(prev_v, (anchor + j) >> 1);
            flat_filled = 1'b1;
         end else begin
            if (prev_v > cur) mid = ((cur + prev_v + 1) >> 1) - 1;
            else mid = ((cur + prev_v) >> 1) + 1;
            while (prev_v != mid) begin
               if (!flat_filled) inverse_put(prev_v, prev_j);
               prev_v += (prev_v > mid) ? -1 : 1;
               flat_filled = 1'b0;
            end
            while (prev_v != cur) begin
               if (!flat_filled) inverse_put(prev_v, j);
               prev_v += (prev_v > cur) ? -1 : 1;
               flat_filled = 1'b0;
            end
            anchor = j;
         end
         prev_j = j;
         prev_v = cur;
      end
      if (!flat_filled) inverse_put(prev_v, prev_j);
      if (outmax > 4) begin
         smooth_end(0, 1, 2, inmax);
         smooth_end(outmax, outmax - 1, outmax - 2, inmax);
      end
      built_top = outmax;
   endfunction

   // Applies one accepted request to the copy and queues its result, if any.
   // A typed expectation, where given, replaces the computed read data.
   function automatic void apply_request(logic [1:0] kind, int addr, int value,
                                         bit typed, logic [13:0] typed_data);
      inv_result_type r;
      int outmax;
      outmax = (1 << out_bits) - 1;
      case (kind)
         tclb_pkg::REQ_WRITE: begin
            if (addr <= (1 << in_bits) - 1) curve_mem[addr] = value[15:0];
         end
         tclb_pkg::REQ_BUILD: begin
            build_inverse_table();
            r.read_data = '0;
            r.build_done = 1'b1;
            pending_results.push_back(r);
         end
         tclb_pkg::REQ_READ: begin
            r.read_data = (addr <= outmax) ? inverse_mem[addr] : '0;
            if (typed) r.read_data = typed_data;
            r.build_done = 1'b0;
            pending_results.push_back(r);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // ------------------------------------------------------------------------
   // Result side: the stall pattern steps through three modes (always ready,
   // random, periodic stall), and each transfer is compared with the oldest pending result.
   // ------------------------------------------------------------------------
   int rsp_cycle = 0;

   always @(posedge clock) begin
      inv_result_type e;
      int mode;
      rsp_cycle++;
      mode = (rsp_cycle / 300) % 3;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result data=%h done=%b",
                                      rsp_tdata, rsp_tuser));
         end else begin
            e = pending_results.pop_front();
            if (rsp_tdata !== {2'b00, e.read_data})
               report_mismatch($sformatf("read_data %h, expected %h",
                                         rsp_tdata, e.read_data));
            if (rsp_tuser !== e.build_done)
               report_mismatch($sformatf("build_done %b, expected %b",
                                         rsp_tuser, e.build_done));
         end
      end
      case (mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 99) < 60);
         default: rsp_tready <= (rsp_cycle % 5 != 0);
      endcase
   end

   // ------------------------------------------------------------------------
   // Request side: bursts of random length separated by random gaps.
   // ------------------------------------------------------------------------
   int burst_left = 0;

   task automatic send_request(input logic [1:0] kind, input int addr, input int value,
                               input bit typed = 1'b0, input logic [13:0] typed_data = '0);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {value[15:0], addr[15:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(kind, addr, value, typed, typed_data);
      burst_left--;
   endtask

   // Stops sending and waits until every pending result has come back, then
   // waits on for a trailing forward write to settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // One register write, after which the write port is left idle before the task returns.
   task automatic write_csr(input logic idx, input int value);
      int v;
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[4:0];
      @(posedge clock);
      csr_we <= 1'b0;
      v = (idx == tclb_pkg::CSR_OUT_DEPTH) ? value & 'h1F : value & 'hF;
      if (v < tclb_pkg::MIN_BITS) v = tclb_pkg::MIN_BITS;
      if (idx == tclb_pkg::CSR_OUT_DEPTH)
         out_bits = (v > tclb_pkg::MAX_OUT_BITS) ? tclb_pkg::MAX_OUT_BITS : v;
      else
         in_bits = (v > tclb_pkg::MAX_IN_BITS) ? tclb_pkg::MAX_IN_BITS : v;
      @(posedge clock);
   endtask

   // Writes every forward entry of the current depth, so that a build never
   // reads an entry that was not written. The shape of the curve varies.
   task automatic load_curve(input int shape);
      int inmax, outmax, v, step;
      inmax = (1 << in_bits) - 1;
      outmax = (1 << out_bits) - 1;
      v = (shape == 1) ? outmax + $urandom_range(0, 3) : $urandom_range(0, 8);
      for (int i = 0; i <= inmax; i++) begin
         case (shape)
            0: begin   // rising with flats and jumps
               step = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3 * outmax / inmax + 4);
               v = (v + step > 65535) ? 65535 : v + step;
            end
            1: begin   // falling
               step = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3 * outmax / inmax + 4);
               v = (v < step) ? 0 : v - step;
            end
            2: v = $urandom_range(0, 65535);   // noise, often above the output range
            default: if (i == 0) v = $urandom_range(0, outmax);
         endcase
         send_request(tclb_pkg::REQ_WRITE, i, v);
      end
   endtask

   typedef struct {
      logic [1:0]  kind;
      int          addr;
      int          value;
      bit          typed;
      logic [13:0] result;
   } stim_row_type;

   // Directed rows on an identity curve at the smallest depths.
   stim_row_type directed_rows [23] = '{
      '{tclb_pkg::REQ_WRITE, 0,     0,     0, 0},
      '{tclb_pkg::REQ_WRITE, 255,   65535, 0, 0},
      '{tclb_pkg::REQ_WRITE, 256,   1234,  0, 0},
      '{tclb_pkg::REQ_WRITE, 65535, 65535, 0, 0},
      '{REQ_UNUSED,          65535, 65535, 0, 0},
      '{tclb_pkg::REQ_BUILD, 0,     0,     0, 0},
      '{tclb_pkg::REQ_READ,  0,     0,     0, 0},
      '{tclb_pkg::REQ_READ,  255,   0,     0, 0},
      '{tclb_pkg::REQ_READ,  128,   0,     0, 0},
      '{tclb_pkg::REQ_READ,  256,   0,     1, 14'd0},
      '{tclb_pkg::REQ_READ,  65535, 65535, 1, 14'd0},
      '{tclb_pkg::REQ_WRITE, 100,   100,   0, 0},
      '{tclb_pkg::REQ_WRITE, 101,   100,   0, 0},
      '{tclb_pkg::REQ_WRITE, 102,   100,   0, 0},
      '{tclb_pkg::REQ_WRITE, 200,   90,    0, 0},
      '{tclb_pkg::REQ_WRITE, 254,   10,    0, 0},
      '{tclb_pkg::REQ_BUILD, 0,     0,     0, 0},
      '{tclb_pkg::REQ_READ,  100,   0,     0, 0},
      '{tclb_pkg::REQ_READ,  90,    0,     0, 0},
      '{REQ_UNUSED,          0,     0,     0, 0},
      '{tclb_pkg::REQ_READ,  0,     0,     0, 0},
      '{tclb_pkg::REQ_READ,  255,   0,     0, 0},
      '{tclb_pkg::REQ_READ,  11,    0,     0, 0}
   };

   // One random phase: new depths, a fresh curve of the given shape, a first
   // build, then a mix of mostly reads and writes with the odd extra build
   // and unused code.
   task automatic random_phase(input int out_val, input int in_val, input int count,
                               input int build_cap, input int shape);
      int outmax, inmax, pick, addr, builds;
      write_csr(tclb_pkg::CSR_OUT_DEPTH, out_val);
      write_csr(tclb_pkg::CSR_IN_DEPTH, in_val);
      load_curve(shape);
      send_request(tclb_pkg::REQ_BUILD, 0, $urandom_range(0, 65535));
      outmax = (1 << out_bits) - 1;
      inmax = (1 << in_bits) - 1;
      builds = 0;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (n == count / 2) drain();
         if (pick < 45) begin
            if ($urandom_range(0, 4) == 0 && outmax < 65535)
               addr = $urandom_range(outmax + 1, 65535);
            else
               addr = $urandom_range(0, (built_top < outmax) ? built_top : outmax);
            send_request(tclb_pkg::REQ_READ, addr, $urandom_range(0, 65535));
         end else if (pick < 90) begin
            addr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, inmax);
            send_request(tclb_pkg::REQ_WRITE, addr, $urandom_range(0, 65535));
         end else if (pick < 95 && builds < build_cap) begin
            send_request(tclb_pkg::REQ_BUILD, $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
            builds++;
         end else begin
            send_request(REQ_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535));
         end
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < tclb_pkg::FWD_DEPTH; i++) curve_mem[i] = '0;
      for (int i = 0; i < tclb_pkg::INV_DEPTH; i++) inverse_mem[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of range depths saturate to the smallest setting.
      write_csr(tclb_pkg::CSR_OUT_DEPTH, 3);
      write_csr(tclb_pkg::CSR_IN_DEPTH, 0);
      for (int i = 0; i < 256; i++) send_request(tclb_pkg::REQ_WRITE, i, i);
      foreach (directed_rows[r])
         send_request(directed_rows[r].kind, directed_rows[r].addr, directed_rows[r].value,
                      directed_rows[r].typed, directed_rows[r].result);
      drain();

      // The largest external depth runs once on a smooth curve with a single
      // build; the shallower phases take any curve shape and a few builds.
      random_phase(31, 8, 150, 0, 0);
      random_phase(10, 9, 250, 3, $urandom_range(0, 3));
      random_phase(12, 0, 50, 1, $urandom_range(0, 3));

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/tclb_pkg.sv
hw/rtl/tclb_smooth.sv
hw/rtl/tone_curve_inverse_lut_builder.sv
tb/tb_top.sv
